// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg
// shared constants for the four-field record parser
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

    localparam int unsigned OUT_VALUE_BITS = 31;

    localparam logic [7:0] CHAR_END      = 8'h00;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] SEP_RESET    = 8'h2c;

    localparam logic [1:0] KIND_NAME1    = 2'd0;
    localparam logic [1:0] KIND_NAME2    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    localparam logic [2:0] FIELD_NAME1   = 3'd0;
    localparam logic [2:0] FIELD_VALUE1  = 3'd1;
    localparam logic [2:0] FIELD_NAME2   = 3'd2;
    localparam logic [2:0] FIELD_VALUE2  = 3'd3;
    localparam logic [2:0] FIELD_OVER    = 3'd4;

    typedef logic [OUT_VALUE_BITS-1:0] t_out_value;

endpackage

`default_nettype wire

// ===== rtl/frp_if.sv =====
// ----------------------------------------------------------------------------
// frp_if
// valid/ready channels for record bytes and parser results
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface frp_result_if
    import frp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] name_char;
    t_out_value first_value;
    t_out_value second_value;
    logic       record_ok;

    modport source (
        output valid, output result_kind, output name_char,
        output first_value, output second_value, output record_ok,
        input  ready
    );
    modport sink (
        input  valid, input result_kind, input name_char,
        input  first_value, input second_value, input record_ok,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/frp_digit_acc.sv =====
// ----------------------------------------------------------------------------
// frp_digit_acc
// saturating decimal accumulate: acc * 10 + digit, clamped to all ones
// ----------------------------------------------------------------------------
`default_nettype none

module frp_digit_acc #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic [VALUE_BITS-1:0] i_acc,
    input  wire logic [3:0]            i_digit,
    output logic      [VALUE_BITS-1:0] o_acc
);

    localparam int unsigned SUM_BITS = VALUE_BITS + 4;

    logic [SUM_BITS-1:0] w_sum;

    // times eight plus times two plus the digit
    assign w_sum = {1'b0, i_acc, 3'b000}
                 + {3'b000, i_acc, 1'b0}
                 + {{VALUE_BITS{1'b0}}, i_digit};

    assign o_acc = (w_sum[SUM_BITS-1:VALUE_BITS] != 4'd0) ? {VALUE_BITS{1'b1}}
                                                         : w_sum[VALUE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/four_field_record_parser.sv =====
// path: an accepted byte is held in the input register and processed there; its
//   result is registered in the output register and offered from there
// throughput: one byte per cycle, bounded by the times-ten accumulate loop on the
//   field state; a byte with a result waits while the output register is held
// reset: synchronous, active low; clears field state and output valid and
//   returns the separator to comma
// ----------------------------------------------------------------------------
// four_field_record_parser
// byte-wise parser for name,number,name,number records ended by a zero byte
// ----------------------------------------------------------------------------
`default_nettype none

module four_field_record_parser
    import frp_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    frp_byte_if.sink        i_byte,
    frp_result_if.source    o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    localparam int unsigned WIDE_BITS = VALUE_BITS + OUT_VALUE_BITS;

    logic [7:0]            r_sep;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [2:0]            r_field_index;
    logic [VALUE_BITS-1:0] r_first_accum;
    logic [VALUE_BITS-1:0] r_second_accum;
    logic                  r_bad_digit;

    logic                  r_out_valid;
    logic [1:0]            r_out_kind;
    logic [7:0]            r_out_char;
    t_out_value            r_out_first;
    t_out_value            r_out_second;
    logic                  r_out_ok;

    logic [2:0]            n_field_index;
    logic [VALUE_BITS-1:0] n_first_accum;
    logic [VALUE_BITS-1:0] n_second_accum;
    logic                  n_bad_digit;
    logic [1:0]            n_out_kind;

    logic                  w_is_end;
    logic                  w_is_sep;
    logic                  w_is_digit;
    logic                  w_has_result;
    logic                  w_out_free;
    logic                  w_advance;
    logic [3:0]            w_digit;
    logic [VALUE_BITS-1:0] w_first_step;
    logic [VALUE_BITS-1:0] w_second_step;
    logic [WIDE_BITS-1:0]  w_first_wide;
    logic [WIDE_BITS-1:0]  w_second_wide;

    assign w_is_end   = (r_in_byte == CHAR_END);
    assign w_is_sep   = (r_in_byte == r_sep);
    assign w_is_digit = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign w_digit    = 4'(r_in_byte - CHAR_ZERO);

    assign w_has_result = w_is_end
                       || (!w_is_sep && ((r_field_index == FIELD_NAME1)
                                      || (r_field_index == FIELD_NAME2)));
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_advance  = r_in_valid && (!w_has_result || w_out_free);

    assign i_byte.ready = !r_in_valid || w_advance;

    frp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_first_acc (
        .i_acc   (r_first_accum),
        .i_digit (w_digit),
        .o_acc   (w_first_step)
    );

    frp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_second_acc (
        .i_acc   (r_second_accum),
        .i_digit (w_digit),
        .o_acc   (w_second_step)
    );

    assign w_first_wide  = {{OUT_VALUE_BITS{1'b0}}, r_first_accum};
    assign w_second_wide = {{OUT_VALUE_BITS{1'b0}}, r_second_accum};

    always_comb begin
        n_field_index  = r_field_index;
        n_first_accum  = r_first_accum;
        n_second_accum = r_second_accum;
        n_bad_digit    = r_bad_digit;
        n_out_kind     = (r_field_index == FIELD_NAME1) ? KIND_NAME1 : KIND_NAME2;
        if (w_is_end) begin
            n_field_index  = FIELD_NAME1;
            n_first_accum  = '0;
            n_second_accum = '0;
            n_bad_digit    = 1'b0;
            n_out_kind     = KIND_SUMMARY;
        end else if (w_is_sep) begin
            if (r_field_index != FIELD_OVER) begin
                n_field_index = r_field_index + 3'd1;
            end
        end else begin
            unique case (r_field_index)
                FIELD_VALUE1: begin
                    if (w_is_digit) begin
                        n_first_accum = w_first_step;
                    end
                end
                FIELD_VALUE2: begin
                    if (w_is_digit) begin
                        n_second_accum = w_second_step;
                    end else begin
                        n_bad_digit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_we) begin
            r_sep <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.text_byte;
        end
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_index  <= FIELD_NAME1;
            r_first_accum  <= '0;
            r_second_accum <= '0;
            r_bad_digit    <= 1'b0;
        end else if (w_advance) begin
            r_field_index  <= n_field_index;
            r_first_accum  <= n_first_accum;
            r_second_accum <= n_second_accum;
            r_bad_digit    <= n_bad_digit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out_kind <= n_out_kind;
            if (w_is_end) begin
                r_out_char   <= 8'h00;
                r_out_first  <= w_first_wide[OUT_VALUE_BITS-1:0];
                r_out_second <= w_second_wide[OUT_VALUE_BITS-1:0];
                r_out_ok     <= (r_field_index == FIELD_VALUE2) && !r_bad_digit;
            end else begin
                r_out_char   <= r_in_byte;
                r_out_first  <= '0;
                r_out_second <= '0;
                r_out_ok     <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_kind  = r_out_kind;
    assign o_result.name_char    = r_out_char;
    assign o_result.first_value  = r_out_first;
    assign o_result.second_value = r_out_second;
    assign o_result.record_ok    = r_out_ok;

    a_field_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_index <= FIELD_OVER)
        else $error("field index beyond saturation");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_end |=> (r_field_index == FIELD_NAME1) && !r_bad_digit
                                  && (r_first_accum == '0) && (r_second_accum == '0))
        else $error("record state not cleared after end of record");

    a_field_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_is_end |=> (r_field_index == $past(r_field_index))
                                   || (r_field_index == $past(r_field_index) + 3'd1))
        else $error("field index jumped");

    a_summary_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_end |=> r_out_valid && (r_out_kind == KIND_SUMMARY))
        else $error("end of record gave no summary");

endmodule

`default_nettype wire
